/* rtl/core/pfsd_pkg.sv */
// Package for the six-color Floyd-Steinberg ditherer: beat structs, item kinds,
// register indexes, the fixed palette and the error-term arithmetic helpers.
// No dependencies; every other file of the block imports it.
package pfsd_pkg;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_HEIGHT = 4096;
  localparam int NUM_CH     = 3;
  localparam int PAL_NUM    = 6;
  localparam int RGB_W      = 24;
  localparam int DIST_W     = 18;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [7:0]        chan_t;
  typedef logic signed [8:0] err_t;
  typedef logic signed [9:0] acc_t;
  typedef logic [2:0]        pal_idx_t;

  // Input beat: one pixel or one flush marker.
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       flush;
  } pix_in_t;

  // Result beat: chosen palette entry and its color.
  typedef struct packed {
    logic [2:0] color_index;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } pix_out_t;

  // What an accepted beat does once it reaches the compute stage.
  typedef enum logic [1:0] {
    KIND_STORE,
    KIND_PIX,
    KIND_FLUSH
  } item_kind_t;

  typedef struct packed {
    logic       keep;
    item_kind_t kind;
    logic       last_col;
    logic       col_nz;
  } item_ctl_t;

  // Palette colors packed as {red, green, blue}.
  function automatic logic [RGB_W-1:0] pal_rgb(input pal_idx_t idx);
    logic [RGB_W-1:0] rgb;
    case (idx)
      3'd0:    rgb = 24'h000000;
      3'd1:    rgb = 24'hFFFFFF;
      3'd2:    rgb = 24'hFF0000;
      3'd3:    rgb = 24'h00FF00;
      3'd4:    rgb = 24'h0000FF;
      3'd5:    rgb = 24'hFFFF00;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

  // Saturate a signed sum to the 0..255 channel range.
  function automatic chan_t clamp8(input acc_t v);
    chan_t r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'hFF;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Error term (e * k) / 16 with truncation toward zero.
  function automatic err_t err_term(input err_t e, input logic [3:0] k);
    logic signed [13:0] prod;
    logic [13:0]        mag;
    logic [13:0]        quo;
    prod = e * $signed({1'b0, k});
    mag  = prod[13] ? 14'(-prod) : 14'(prod);
    quo  = mag >> 4;
    return prod[13] ? err_t'(-$signed(quo)) : err_t'(quo);
  endfunction

endpackage

/* rtl/core/palette_floyd_steinberg_dither.sv */
// Top level of the six-color Floyd-Steinberg ditherer.
// Depends on pfsd_pkg, pfsd_seq, pfsd_row_store and pfsd_diffuse.
//
// Usage: RGB888 pixels enter on the in_ channel in raster order, one beat per
// pixel; results leave on the out_ channel as palette index plus color. Both
// channels use valid/ready. The cfg_ port writes line_width and frame_height
// and is to be used only while the block is idle; the block does not enforce it.
// The output runs one row behind the input: the first row only fills the row
// store, and each pixel of a later row releases the pixel above it. After the
// last row, line_width flush beats drain the stored row; the final result
// beat carries frame_last.
// Timing: a beat is registered at acceptance (the row store is read at the
// same edge), the quantize and diffuse logic works on it in the input stage
// and its result is registered into the output stage. A released result
// thus passes the input stage register and then the output register. One
// beat is taken per cycle while the output and the row store write port are
// free; the single write port sets that figure, and the second write at the
// end of a row is parked in a one-entry buffer that drains on the following cycle.
// Reset clears counters, error terms and both stages; the row store is not
// cleared. When the receiver stalls, one beat waits in the output register and
// one more in the input stage before in_ready falls.
module palette_floyd_steinberg_dither #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pfsd_pkg::pix_in_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pfsd_pkg::pix_out_t              out_data,
  input  logic                            cfg_we,
  input  logic [pfsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfsd_pkg::CFG_W-1:0]      cfg_wdata
);
  import pfsd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [CFG_W-1:0] line_width_r, frame_height_r;

  // Input stage.
  logic             s1_valid_r, s1_valid_nxt;
  item_ctl_t        s1_ctl_r;
  logic [AW-1:0]    s1_col_r;
  logic [RGB_W-1:0] s1_rgb_r;
  logic             byp_hit_r;
  logic [RGB_W-1:0] byp_data_r, byp_data_nxt;
  logic             byp_hit_nxt;

  // Pending end-of-row write.
  logic             pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]    pend_addr_r;
  logic [RGB_W-1:0] pend_data_r;

  // Output stage.
  logic             out_valid_r;
  pix_out_t         out_data_r;

  logic             in_acc, s1_go, s1_has_res, s1_needs_wr, out_free;
  logic [AW-1:0]    seq_col;
  item_ctl_t        seq_ctl;
  logic             dwr_en, pend_set;
  logic [AW-1:0]    dwr_addr;
  logic [RGB_W-1:0] dwr_data;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [RGB_W-1:0] mem_wr_data, mem_rd_data, s1_pix;
  logic [RGB_W-1:0] in_rgb, below_rgb, next_rgb;
  pix_out_t         res;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= CFG_W'(1);
      frame_height_r <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   line_width_r   <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_rgb = {in_data.red_in, in_data.green_in, in_data.blue_in};
  assign in_acc = in_valid && in_ready;

  pfsd_seq #(
    .DEPTH (MAX_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_acc       (in_acc),
    .flush        (in_data.flush),
    .line_width   (line_width_r),
    .frame_height (frame_height_r),
    .col          (seq_col),
    .ctl          (seq_ctl)
  );

  // Stage handshake: a beat completes when its result has room and the store
  // write port is not taken by the pending end-of-row write.
  assign out_free    = !out_valid_r || out_ready;
  assign s1_has_res  = (s1_ctl_r.kind != KIND_STORE);
  assign s1_needs_wr = (s1_ctl_r.kind == KIND_STORE) ||
                       ((s1_ctl_r.kind == KIND_PIX) && (s1_ctl_r.col_nz || s1_ctl_r.last_col));
  assign s1_go       = s1_valid_r && (!s1_has_res || out_free) &&
                       !(pend_valid_r && s1_needs_wr);
  assign in_ready    = !s1_valid_r || s1_go;

  // Direct row-store write of the completing beat.
  always_comb begin
    dwr_en   = s1_go && s1_needs_wr;
    dwr_addr = s1_col_r;
    dwr_data = next_rgb;
    if (s1_ctl_r.kind == KIND_STORE) begin
      dwr_data = s1_rgb_r;
    end else if (s1_ctl_r.col_nz) begin
      dwr_addr = s1_col_r - AW'(1);
      dwr_data = below_rgb;
    end
  end

  assign pend_set = s1_go && (s1_ctl_r.kind == KIND_PIX) && s1_ctl_r.last_col &&
                    s1_ctl_r.col_nz;

  // Write port arbitration: the completing beat first, else the parked write.
  always_comb begin
    mem_wr_en   = dwr_en || pend_valid_r;
    mem_wr_addr = dwr_en ? dwr_addr : pend_addr_r;
    mem_wr_data = dwr_en ? dwr_data : pend_data_r;
    if (pend_set) begin
      pend_valid_nxt = 1'b1;
    end else if (dwr_en) begin
      pend_valid_nxt = pend_valid_r;
    end else begin
      pend_valid_nxt = 1'b0;
    end
  end

  // Forward writes not yet visible to the read issued at this edge.
  always_comb begin
    byp_hit_nxt  = 1'b0;
    byp_data_nxt = mem_rd_data;
    if (pend_set && (s1_col_r == seq_col)) begin
      byp_hit_nxt  = 1'b1;
      byp_data_nxt = next_rgb;
    end else if (dwr_en && (dwr_addr == seq_col)) begin
      byp_hit_nxt  = 1'b1;
      byp_data_nxt = dwr_data;
    end else if (pend_valid_r && (pend_addr_r == seq_col)) begin
      byp_hit_nxt  = 1'b1;
      byp_data_nxt = pend_data_r;
    end
  end

  pfsd_row_store #(
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (in_acc),
    .rd_addr (seq_col),
    .rd_data (mem_rd_data)
  );

  assign s1_pix = byp_hit_r ? byp_data_r : mem_rd_data;

  pfsd_diffuse u_diffuse (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .ctl       (s1_ctl_r),
    .pix       (s1_pix),
    .in_rgb    (s1_rgb_r),
    .res       (res),
    .below_rgb (below_rgb),
    .next_rgb  (next_rgb)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = seq_ctl.keep;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Control state of both stages and the parked write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (s1_go && s1_has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r   <= seq_ctl;
      s1_col_r   <= seq_col;
      s1_rgb_r   <= in_rgb;
      byp_hit_r  <= byp_hit_nxt;
      byp_data_r <= byp_data_nxt;
    end
    if (pend_set) begin
      pend_addr_r <= s1_col_r;
      pend_data_r <= next_rgb;
    end
    if (s1_go && s1_has_res) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The completing beat never competes with the parked write for the port.
  a_wr_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(dwr_en && pend_valid_r))
    else $error("row store write port claimed twice");

  // A parked end-of-row write drains on the very next edge.
  a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |=> !pend_valid_r)
    else $error("parked row store write did not drain");

  // The column position always addresses a row store entry.
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(seq_col) < MAX_WIDTH)
    else $error("column position beyond the row store");

endmodule

/* rtl/core/pfsd_row_store.sv */
// Row store of the ditherer: one line of RGB pixels, one write port and one
// registered read port. Uses pfsd_pkg for the pixel word width.
module pfsd_row_store #(
  parameter int DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [pfsd_pkg::RGB_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [pfsd_pkg::RGB_W-1:0]    rd_data
);
  import pfsd_pkg::*;

  logic [RGB_W-1:0] mem [DEPTH];
  logic [RGB_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; returns the old word on a same-cycle write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/pfsd_seq.sv */
// Position tracking of the ditherer: column and row counters and the sorting of
// each accepted beat into store, pixel, flush or dropped. Uses pfsd_pkg.
module pfsd_seq #(
  parameter int DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_acc,
  input  logic                          flush,
  input  logic [pfsd_pkg::CFG_W-1:0]    line_width,
  input  logic [pfsd_pkg::CFG_W-1:0]    frame_height,
  output logic [$clog2(DEPTH)-1:0]      col,
  output pfsd_pkg::item_ctl_t           ctl
);
  import pfsd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0]    col_r, col_nxt;
  logic [CFG_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] w_eff, h_eff, col_inc;
  logic             last_col, col_nz;

  // Effective geometry: zero acts as one, oversize values saturate.
  always_comb begin
    if (line_width == '0) begin
      w_eff = CFG_W'(1);
    end else if (line_width > CFG_W'(DEPTH)) begin
      w_eff = CFG_W'(DEPTH);
    end else begin
      w_eff = line_width;
    end
    if (frame_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (frame_height > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign col_inc  = CFG_W'(col_r) + CFG_W'(1);
  assign last_col = (col_inc >= w_eff);
  assign col_nz   = (col_r != '0);

  // Classify the beat on the port and work out the next position.
  always_comb begin
    ctl.keep     = 1'b0;
    ctl.kind     = KIND_PIX;
    ctl.last_col = last_col;
    ctl.col_nz   = col_nz;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (flush) begin
      ctl.kind = KIND_FLUSH;
      if (row_r != '0) begin
        ctl.keep = 1'b1;
        if (last_col) begin
          col_nxt = '0;
          row_nxt = '0;
        end else begin
          col_nxt = col_r + AW'(1);
        end
      end
    end else if (row_r < h_eff) begin
      ctl.keep = 1'b1;
      ctl.kind = (row_r == '0) ? KIND_STORE : KIND_PIX;
      if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + CFG_W'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  // Counters advance on every accepted beat that is not dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;

endmodule

/* rtl/core/pfsd_diffuse.sv */
// Quantize and diffuse datapath of the ditherer: nearest palette search, error
// terms, and the right, diagonal and pending below-left registers. Uses pfsd_pkg.
module pfsd_diffuse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  pfsd_pkg::item_ctl_t           ctl,
  input  logic [pfsd_pkg::RGB_W-1:0]    pix,
  input  logic [pfsd_pkg::RGB_W-1:0]    in_rgb,
  output pfsd_pkg::pix_out_t            res,
  output logic [pfsd_pkg::RGB_W-1:0]    below_rgb,
  output logic [pfsd_pkg::RGB_W-1:0]    next_rgb
);
  import pfsd_pkg::*;

  err_t             right_r [NUM_CH];
  err_t             diag_r  [NUM_CH];
  chan_t            lbv_r   [NUM_CH];

  chan_t            v       [NUM_CH];
  logic [15:0]      sq_lo   [NUM_CH];
  logic [15:0]      sq_hi   [NUM_CH];
  err_t             e       [NUM_CH];
  err_t             t7      [NUM_CH];
  err_t             t5      [NUM_CH];
  err_t             t3      [NUM_CH];
  err_t             t1      [NUM_CH];
  chan_t            n1      [NUM_CH];
  logic [DIST_W-1:0] cand_cost, best_cost;
  logic [RGB_W-1:0] cand_rgb, best_rgb;
  pal_idx_t         best;

  // Stored pixel plus its right-hand error, and both squared distances per channel.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      v[ch]     = clamp8(acc_t'(pix[8*(NUM_CH-1-ch) +: 8]) + acc_t'(right_r[ch]));
      sq_lo[ch] = 16'(v[ch]) * 16'(v[ch]);
      sq_hi[ch] = 16'(8'd255 - v[ch]) * 16'(8'd255 - v[ch]);
    end
  end

  // Nearest palette entry; a strict compare keeps the lower index on a tie.
  always_comb begin
    best      = '0;
    best_cost = '1;
    cand_cost = '0;
    cand_rgb  = '0;
    for (int i = 0; i < PAL_NUM; i++) begin
      cand_rgb  = pal_rgb(pal_idx_t'(i));
      cand_cost = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        cand_cost = cand_cost + DIST_W'(cand_rgb[8*(NUM_CH-1-ch)+7] ? sq_hi[ch] : sq_lo[ch]);
      end
      if (cand_cost < best_cost) begin
        best_cost = cand_cost;
        best      = pal_idx_t'(i);
      end
    end
    best_rgb = pal_rgb(best);
  end

  // Quantization error, its four shares, and the values handed to the row below.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      e[ch]  = err_t'(acc_t'(v[ch]) - acc_t'(best_rgb[8*(NUM_CH-1-ch) +: 8]));
      t7[ch] = err_term(e[ch], 4'd7);
      t5[ch] = err_term(e[ch], 4'd5);
      t3[ch] = err_term(e[ch], 4'd3);
      t1[ch] = err_term(e[ch], 4'd1);
      n1[ch] = clamp8(acc_t'(in_rgb[8*(NUM_CH-1-ch) +: 8])
                      + (ctl.col_nz ? acc_t'(diag_r[ch]) : acc_t'(0)));
      next_rgb[8*(NUM_CH-1-ch) +: 8]  = clamp8(acc_t'(n1[ch]) + acc_t'(t5[ch]));
      below_rgb[8*(NUM_CH-1-ch) +: 8] = clamp8(acc_t'(lbv_r[ch]) + acc_t'(t3[ch]));
    end
  end

  // Result beat.
  always_comb begin
    res.color_index = best;
    res.red_out     = best_rgb[23:16];
    res.green_out   = best_rgb[15:8];
    res.blue_out    = best_rgb[7:0];
    res.frame_last  = (ctl.kind == KIND_FLUSH) && ctl.last_col;
  end

  // Error state; the end of a row clears all of it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        right_r[ch] <= '0;
        diag_r[ch]  <= '0;
        lbv_r[ch]   <= '0;
      end
    end else if (go) begin
      case (ctl.kind)
        KIND_PIX: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (ctl.last_col) begin
              right_r[ch] <= '0;
              diag_r[ch]  <= '0;
              lbv_r[ch]   <= '0;
            end else begin
              right_r[ch] <= t7[ch];
              diag_r[ch]  <= t1[ch];
              lbv_r[ch]   <= next_rgb[8*(NUM_CH-1-ch) +: 8];
            end
          end
        end
        KIND_FLUSH: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (ctl.last_col) begin
              right_r[ch] <= '0;
              diag_r[ch]  <= '0;
              lbv_r[ch]   <= '0;
            end else begin
              right_r[ch] <= t7[ch];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
